FILE: rtl/wrs_pkg.sv
package wrs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int WEIGHT_BITS = 16;

    localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_BITS    = WEIGHT_BITS + IDX_BITS;

    // Field widths of the words on the ports
    localparam int CFG_BITS    = 5;
    localparam int IN_IDX_BITS = 4;
    localparam int IN_WT_BITS  = 16;
    localparam int RND_BITS    = 31;
    localparam int OUT_IDX_BITS = 4;
    localparam int RND_CNT_BITS = $clog2(RND_BITS);

    localparam logic [CFG_BITS-1:0] ENTRY_COUNT_RESET = CFG_BITS'(16);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [IN_IDX_BITS-1:0]  entry_index;
        logic [IN_WT_BITS-1:0]   weight_value;
        logic [RND_BITS-1:0]     random_value;
    } t_in_word;

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] winner_index;
        logic                    no_winner;
    } t_out_word;

endpackage

FILE: rtl/wrs_table.sv
module wrs_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [wrs_pkg::IDX_BITS-1:0]     i_waddr,
    input  logic [wrs_pkg::WEIGHT_BITS-1:0]  i_wdata,
    input  logic [wrs_pkg::IDX_BITS-1:0]     i_raddr,
    output logic [wrs_pkg::WEIGHT_BITS-1:0]  o_rdata
);
    import wrs_pkg::*;

    logic [WEIGHT_BITS-1:0] r_weight [MAX_ENTRIES];

    // Clear every weight at reset; one write port, one read port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_weight[i] <= '0;
            end
        end else if (i_we) begin
            r_weight[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_weight[i_raddr];

endmodule

FILE: rtl/wrs_mod.sv
module wrs_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wrs_pkg::RND_BITS-1:0]  i_dividend,
    input  logic [wrs_pkg::SUM_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [wrs_pkg::SUM_BITS-1:0]  o_rem
);
    import wrs_pkg::*;

    logic                    r_busy;
    logic [RND_CNT_BITS-1:0] r_cnt;
    logic [RND_BITS-1:0]     r_quo;
    logic [SUM_BITS-1:0]     r_rem;
    logic [SUM_BITS-1:0]     r_div;
    logic                    r_done;
    logic [SUM_BITS:0]       n_trial;
    logic [SUM_BITS-1:0]     n_rem;

    // Restoring remainder step: shift in one dividend bit, subtract if it fits.
    always_comb begin
        n_trial = {r_rem, r_quo[RND_BITS-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = SUM_BITS'(n_trial - {1'b0, r_div});
        end else begin
            n_rem = SUM_BITS'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= RND_CNT_BITS'(RND_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[RND_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/weighted_random_select.sv
// Channel  | Signals                      | Handshake
// ---------+------------------------------+------------------------------------------
// input    | i_start, i_word, o_busy      | word taken when i_start high and o_busy low
// result   | o_done, o_result             | word valid for the one cycle o_done is high
// config   | i_cfg_we, i_cfg_wdata        | entry_count written when i_cfg_we is high
//
// A write word updates the table in the cycle it is taken and gives no result.
// A draw works over the N active entries (at most 16) in this order:
// a sum pass over the table, a 31-step bit-serial remainder, then a prefix scan.
// The sum pass and the prefix scan share the one table read port; the remainder works one bit per cycle.
// Reset (synchronous, low) clears the weight table and sets entry_count to 16.
// The receiver cannot stall; each result shows for exactly one cycle.
module weighted_random_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  wrs_pkg::t_in_word                 i_word,
    output logic                              o_done,
    output wrs_pkg::t_out_word                o_result,
    input  logic                              i_cfg_we,
    input  logic [wrs_pkg::CFG_BITS-1:0]      i_cfg_wdata
);
    import wrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_MOD  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_BITS-1:0]   r_entry_count;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    logic [SUM_BITS-1:0]   r_total, n_total;
    logic [SUM_BITS-1:0]   r_run, n_run;
    logic [SUM_BITS-1:0]   r_choice, n_choice;
    logic [RND_BITS-1:0]   r_rnd, n_rnd;
    logic                  r_done, n_done;
    t_out_word             r_result, n_result;

    logic                  w_accept;
    logic                  w_tbl_we;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic                  w_mod_start;
    logic                  w_mod_done;
    logic [SUM_BITS-1:0]   w_mod_rem;
    logic [SUM_BITS-1:0]   w_run_sum;
    logic [CNT_BITS-1:0]   w_sat_count;

    assign w_accept = i_start && (r_state == S_IDLE);

    // Drop writes that land beyond the table.
    assign w_tbl_we = w_accept && (i_word.cmd == CMD_WRITE)
                      && (int'(i_word.entry_index) < MAX_ENTRIES);

    // Saturate the configured count at the table size.
    assign w_sat_count = (int'(r_entry_count) > MAX_ENTRIES) ?
                         CNT_BITS'(MAX_ENTRIES) : CNT_BITS'(r_entry_count);

    assign w_run_sum = r_run + SUM_BITS'(w_rdata);

    wrs_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_tbl_we),
        .i_waddr (IDX_BITS'(i_word.entry_index)),
        .i_wdata (WEIGHT_BITS'(i_word.weight_value)),
        .i_raddr (r_idx[IDX_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    wrs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_total),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Sequencer: sum pass, remainder, prefix scan.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_total     = r_total;
        n_run       = r_run;
        n_choice    = r_choice;
        n_rnd       = r_rnd;
        n_done      = 1'b0;
        n_result    = r_result;
        w_mod_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_word.cmd == CMD_DRAW)) begin
                    n_rnd   = i_word.random_value;
                    n_count = w_sat_count;
                    n_idx   = '0;
                    n_total = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_idx == r_count) begin
                    if (r_total == '0) begin
                        // Empty wheel: report no winner.
                        n_done   = 1'b1;
                        n_result = '{winner_index: '0, no_winner: 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = S_MOD;
                    end
                end else begin
                    n_total = r_total + SUM_BITS'(w_rdata);
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_choice = w_mod_rem;
                    n_idx    = '0;
                    n_run    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_choice < w_run_sum) begin
                    n_done   = 1'b1;
                    n_result = '{winner_index: OUT_IDX_BITS'(r_idx), no_winner: 1'b0};
                    n_state  = S_IDLE;
                end else if ((r_idx + 1'b1) >= r_count) begin
                    // Hold the safe answer if the scan runs off the end.
                    n_done   = 1'b1;
                    n_result = '{winner_index: '0, no_winner: 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    n_run = w_run_sum;
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_done        <= 1'b0;
            r_entry_count <= ENTRY_COUNT_RESET;
            r_idx         <= '0;
            r_count       <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total  <= n_total;
        r_run    <= n_run;
        r_choice <= n_choice;
        r_rnd    <= n_rnd;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
